// ===== design/crc8cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8cfp_pkg
// Shared types and constants of the CRC-8 command frame parser: frame limits,
// CRC polynomial, register indexes, parser states and the CRC unit request.
// ----------------------------------------------------------------------------
package crc8cfp_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int LEN_W       = 7;   // holds 0..MAX_PAYLOAD
	localparam int POS_W       = 6;   // addresses MAX_PAYLOAD store entries

	localparam logic [7:0] CRC_POLY = 8'h31;

	localparam logic [7:0] FIRST_HDR_RESET  = 8'd170;
	localparam logic [7:0] SECOND_HDR_RESET = 8'd85;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_HDR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_HDR = 2'd1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR1,
		PH_HDR2,
		PH_CMD,
		PH_DATA,
		PH_CHECK,
		PH_EMIT_WAIT,
		PH_EMIT_LOAD
	} phase_t;

	typedef struct packed {
		logic       start;
		logic       restart;  // start from a zero CRC instead of the running one
		logic [7:0] data;
	} crc_req_t;

	// One MSB-first shift of the CRC register.
	function automatic logic [7:0] crc_bit_step(input logic [7:0] c);
		logic [7:0] s;
		s = {c[6:0], 1'b0};
		if (c[7]) begin
			s = s ^ CRC_POLY;
		end
		return s;
	endfunction

endpackage

// ===== design/crc8cfp_crc.sv =====
// ----------------------------------------------------------------------------
// crc8cfp_crc
// Iterative CRC-8 unit: folds one byte into the running CRC, two bits per
// cycle, and stays busy until all eight bits of the byte are folded in.
// ----------------------------------------------------------------------------
module crc8cfp_crc
	import crc8cfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  crc_req_t   req,
	output logic       busy,
	output logic [7:0] crc
);

	logic [7:0] crc_q;
	logic [1:0] cnt_q;
	logic       busy_q;
	logic [7:0] crc_next;

	always_comb begin
		crc_next = crc_bit_step(crc_bit_step(crc_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (req.start) begin
			crc_q  <= (req.restart ? 8'h00 : crc_q) ^ req.data;
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q <= crc_next;
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign crc  = crc_q;

endmodule

// ===== design/crc8_command_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// crc8_command_frame_parser_top
// Frame parser for header 1, header 2, command, length, payload, CRC-8 frames.
// ----------------------------------------------------------------------------
// Received bytes come in one per transfer on the input channel. Header bytes
// and the check byte are compared as they are taken; the command, length and
// every payload byte are taken and then folded in by the shared CRC-8 unit,
// which folds two bits per cycle (polynomial 0x31, init 0, MSB first); input
// stalls while it is busy. A frame whose CRC matches is then read out of the
// 64-byte payload store as a run of results, each a store read and then an
// output register load, held while the output is stalled; no input is taken
// during that run. A zero-length frame gives one result with has_payload low.
// Frames with a bad CRC or a length above 64 give no result. The user is to
// set header byte values through the configuration port only while the block
// is idle; the block itself does not enforce this.
module crc8_command_frame_parser_top
	import crc8cfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	// received bytes
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rx_byte,
	// frame results
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           command_code,
	output logic [LEN_W-1:0]     frame_length,
	output logic [POS_W-1:0]     byte_position,
	output logic [7:0]           payload_value,
	output logic                 has_payload,
	output logic                 last
);

	phase_t state_q, state_d;

	logic [7:0]       hdr1_q, hdr2_q;
	logic [7:0]       held_cmd_q;
	logic [LEN_W-1:0] held_len_q;
	logic [LEN_W-1:0] rcv_q;
	logic [POS_W-1:0] idx_q;

	logic [7:0] store_mem [MAX_PAYLOAD];
	logic [7:0] rdata_q;

	logic             out_valid_q;
	logic [7:0]       out_cmd_q;
	logic [LEN_W-1:0] out_len_q;
	logic [POS_W-1:0] out_pos_q;
	logic [7:0]       out_val_q;
	logic             out_has_q;
	logic             out_last_q;

	crc_req_t   crc_req;
	logic       crc_busy;
	logic [7:0] crc_val;

	logic acc;
	logic mem_we;
	logic out_free;
	logic load_out;
	logic run_last;

	crc8cfp_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (crc_req),
		.busy   (crc_busy),
		.crc    (crc_val)
	);

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr1_q <= FIRST_HDR_RESET;
			hdr2_q <= SECOND_HDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FIRST_HDR:  hdr1_q <= cfg_data;
				REG_SECOND_HDR: hdr2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = crc_busy || (state_q == PH_EMIT_WAIT) || (state_q == PH_EMIT_LOAD);
	assign acc      = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign run_last = (held_len_q == '0) ||
	                  ({1'b0, idx_q} + LEN_W'(1) == held_len_q);

	// Parser sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		crc_req.start   = 1'b0;
		crc_req.restart = 1'b0;
		crc_req.data    = rx_byte;
		mem_we          = 1'b0;
		load_out        = 1'b0;
		case (state_q)
			PH_IDLE: begin
				if (acc && rx_byte == hdr1_q) begin
					state_d = PH_HDR1;
				end
			end
			PH_HDR1: begin
				if (acc) begin
					state_d = (rx_byte == hdr2_q) ? PH_HDR2 : PH_IDLE;
				end
			end
			PH_HDR2: begin
				if (acc) begin
					crc_req.start   = 1'b1;
					crc_req.restart = 1'b1;
					state_d         = PH_CMD;
				end
			end
			PH_CMD: begin
				if (acc) begin
					if (rx_byte > 8'(MAX_PAYLOAD)) begin
						state_d = PH_IDLE;
					end else begin
						crc_req.start = 1'b1;
						state_d = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (acc) begin
					mem_we        = 1'b1;
					crc_req.start = 1'b1;
					if (rcv_q + LEN_W'(1) >= held_len_q) begin
						state_d = PH_CHECK;
					end
				end
			end
			PH_CHECK: begin
				if (acc) begin
					state_d = (rx_byte == crc_val) ? PH_EMIT_WAIT : PH_IDLE;
				end
			end
			PH_EMIT_WAIT: begin
				// The store read for the current index lands in rdata_q here.
				state_d = PH_EMIT_LOAD;
			end
			PH_EMIT_LOAD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = run_last ? PH_IDLE : PH_EMIT_WAIT;
				end
			end
			default: state_d = PH_IDLE;
		endcase
	end

	// Frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cmd_q <= '0;
			held_len_q <= '0;
			rcv_q      <= '0;
			idx_q      <= '0;
		end else begin
			if (acc && state_q == PH_HDR2) begin
				held_cmd_q <= rx_byte;
			end
			if (acc && state_q == PH_CMD) begin
				rcv_q <= '0;
				if (rx_byte <= 8'(MAX_PAYLOAD)) begin
					held_len_q <= rx_byte[LEN_W-1:0];
				end
			end
			if (mem_we) begin
				rcv_q <= rcv_q + LEN_W'(1);
			end
			if (acc && state_q == PH_CHECK) begin
				idx_q <= '0;
			end
			if (load_out && !run_last) begin
				idx_q <= idx_q + POS_W'(1);
			end
		end
	end

	// Payload store; the length check keeps the write index below the depth.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[rcv_q[POS_W-1:0]] <= rx_byte;
		end
		rdata_q <= store_mem[idx_q];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_cmd_q  <= held_cmd_q;
			out_len_q  <= held_len_q;
			out_pos_q  <= idx_q;
			out_has_q  <= (held_len_q != '0);
			out_val_q  <= (held_len_q != '0) ? rdata_q : 8'h00;
			out_last_q <= run_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign command_code  = out_cmd_q;
	assign frame_length  = out_len_q;
	assign byte_position = out_pos_q;
	assign payload_value = out_val_q;
	assign has_payload   = out_has_q;
	assign last          = out_last_q;

endmodule
